@@ rtl/core/fls_pkg.sv @@
// shared types, constants and coefficient generation for the fir low-pass unit
`timescale 1ns / 1ps
`default_nettype none

package fls_pkg;

    // sample and result widths fixed by the stream format
    localparam int FLS_SAMPLE_W = 16;
    localparam int FLS_SCALE_W  = 15;

    // decay ratio per tap, exp(-2*pi*1000/44100), unsigned q32
    localparam logic [31:0] FLS_RATIO_Q32 = 32'd3724632105;

    // sequencer states
    typedef enum logic [1:0] {
        FLS_IDLE,
        FLS_RUN,
        FLS_DRAIN
    } t_fls_state;

    // coefficient of one tap, unsigned with frac fraction bits, rounded half up
    function automatic logic [31:0] fls_coef(input int idx, input int frac);
        logic [95:0] p;
        logic [95:0] r;
        p = 96'h1_0000_0000;
        for (int j = 0; j < idx; j++) begin
            p = (p * 96'(FLS_RATIO_Q32) + (96'd1 << 31)) >> 32;
        end
        r = (p + (96'd1 << (31 - frac))) >> (32 - frac);
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fls_sat.sv @@
// clamp, full-scale multiply and output register of the fir low-pass unit
`timescale 1ns / 1ps
`default_nettype none

module fls_sat
    import fls_pkg::*;
#(
    parameter int ACC_W = 40,
    parameter int SH    = 30
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_load,
    input  wire  signed [ACC_W-1:0]      i_acc,
    output logic                         o_ready,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    output logic [FLS_SAMPLE_W-1:0]      o_m_tdata,  // [15:0] filtered
    output logic                         o_m_tuser   // [0] clipped
);

    localparam logic signed [ACC_W-1:0] ONE =
        {{(ACC_W-SH-1){1'b0}}, 1'b1, {SH{1'b0}}};
    localparam int PROD_W = SH + 1 + FLS_SCALE_W;

    logic                     w_over;
    logic                     w_under;
    logic                     w_neg;
    logic [ACC_W-1:0]         w_mag_full;
    logic [SH:0]              w_mag;
    logic [PROD_W-1:0]        w_scaled;
    logic [FLS_SCALE_W-1:0]   w_q;
    logic [FLS_SAMPLE_W-1:0]  n_data;
    logic                     n_clip;

    logic                     r_valid;
    logic [FLS_SAMPLE_W-1:0]  r_data;
    logic                     r_clip;

    // clamp to +/-1 and scale by 32767 as (mag << 15) - mag, truncating toward zero
    always_comb begin
        w_over     = i_acc > ONE;
        w_under    = i_acc < -ONE;
        w_neg      = i_acc[ACC_W-1];
        w_mag_full = w_neg ? ACC_W'(-i_acc) : ACC_W'(i_acc);
        w_mag      = w_mag_full[SH:0];
        w_scaled   = {w_mag, {FLS_SCALE_W{1'b0}}} - PROD_W'(w_mag);
        w_q        = w_scaled[SH+FLS_SCALE_W-1:SH];
        if (w_over) begin
            n_data = {1'b0, {FLS_SCALE_W{1'b1}}};
            n_clip = 1'b1;
        end else if (w_under) begin
            n_data = -{1'b0, {FLS_SCALE_W{1'b1}}};
            n_clip = 1'b1;
        end else begin
            n_data = w_neg ? -{1'b0, w_q} : {1'b0, w_q};
            n_clip = 1'b0;
        end
    end

    // output beat holding register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
            r_clip <= n_clip;
        end
    end

    assign o_ready    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_clip;

endmodule

`default_nettype wire

@@ rtl/core/fir_lowpass_saturating_unit.sv @@
// top level of the saturating fir low-pass unit
//
// usage: audio samples enter as beats on the slave stream (i_s_*), one signed
// 16-bit q15 sample per beat in i_s_tdata. each sample produces exactly one
// beat on the master stream (o_m_*): o_m_tdata holds the filtered sample and
// o_m_tuser flags that the tap sum went beyond +/-1 and was clamped.
// the delay line lives in a single-port synchronous ram used as a ring
// buffer; the new sample is written at acceptance, then one tap is read and
// multiplied-accumulated per cycle against a constant coefficient table.
// a new sample is taken only once the previous one has left the drain step,
// a limit set by the single read port and the one multiplier shared by all
// taps. o_s_tready is high only while the sequencer is idle.
// a finished result sits in the output register; the next sample is taken
// while it waits, and a second result only stalls in the drain step until
// the receiver takes the first, so no beat is lost under backpressure.
// reset (synchronous, active low) clears the per-entry valid bits, so the
// delay line reads as all zero, and empties the sequencer and output.
`timescale 1ns / 1ps
`default_nettype none

module fir_lowpass_saturating_unit
    import fls_pkg::*;
#(
    parameter int TAPS      = 20,
    parameter int COEF_BITS = 17
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_s_tvalid,
    output logic                     o_s_tready,
    input  wire  [FLS_SAMPLE_W-1:0]  i_s_tdata,   // [15:0] sample
    output logic                     o_m_tvalid,
    input  wire                      i_m_tready,
    output logic [FLS_SAMPLE_W-1:0]  o_m_tdata,   // [15:0] filtered
    output logic                     o_m_tuser    // [0] clipped
);

    localparam int CFRAC  = COEF_BITS - 2;
    localparam int PTR_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W = FLS_SAMPLE_W + COEF_BITS + 1;
    localparam int ACC_W  = PROD_W + PTR_W;
    localparam int SH     = CFRAC + FLS_SCALE_W;
    localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAPS - 1);

    t_fls_state                r_state;
    t_fls_state                n_state;

    logic                      w_accept;
    logic                      w_issue;
    logic                      w_load;
    logic                      w_sat_ready;
    logic                      w_pipe_empty;

    logic [PTR_W-1:0]          r_wr_ptr;
    logic [PTR_W-1:0]          r_rd_ptr;
    logic [PTR_W-1:0]          r_tap;

    logic [FLS_SAMPLE_W-1:0]   r_mem [TAPS];
    logic [TAPS-1:0]           r_vld;

    logic [COEF_BITS-1:0]      w_coef_rom [TAPS];

    logic                      r_p1_vld;
    logic                      r_p2_vld;
    logic [FLS_SAMPLE_W-1:0]   r_rd_data;
    logic                      r_rd_vld;
    logic [COEF_BITS-1:0]      r_coef;
    logic signed [FLS_SAMPLE_W-1:0] w_tap_sample;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;

    // coefficient table, decaying exponential worked out at elaboration
    for (genvar g = 0; g < TAPS; g++) begin : g_coef
        assign w_coef_rom[g] = COEF_BITS'(fls_coef(g, CFRAC));
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FLS_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = FLS_RUN;
                end
            end
            FLS_RUN: begin
                if (r_tap == LAST_TAP) begin
                    n_state = FLS_DRAIN;
                end
            end
            FLS_DRAIN: begin
                if (w_pipe_empty && w_sat_ready) begin
                    n_state = FLS_IDLE;
                end
            end
            default: n_state = FLS_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_tready = 1'b0;
        w_issue    = 1'b0;
        w_load     = 1'b0;
        case (r_state)
            FLS_IDLE:  o_s_tready = 1'b1;
            FLS_RUN:   w_issue    = 1'b1;
            FLS_DRAIN: w_load     = w_pipe_empty && w_sat_ready;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_pipe_empty = !r_p1_vld && !r_p2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FLS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring pointers and tap counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_tap    <= '0;
        end else if (w_accept) begin
            r_wr_ptr <= (r_wr_ptr == LAST_TAP) ? '0 : r_wr_ptr + 1'b1;
            r_rd_ptr <= r_wr_ptr;
            r_tap    <= '0;
        end else if (w_issue) begin
            r_rd_ptr <= (r_rd_ptr == '0) ? LAST_TAP : r_rd_ptr - 1'b1;
            r_tap    <= r_tap + 1'b1;
        end
    end

    // delay line ram: write on acceptance, one registered read per tap;
    // reads start the cycle after the write so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mem[r_wr_ptr] <= i_s_tdata;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
            r_coef    <= w_coef_rom[r_tap];
        end
    end

    // entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_vld[r_wr_ptr] <= 1'b1;
            end
            if (w_issue) begin
                r_rd_vld <= r_vld[r_rd_ptr];
            end
            r_p1_vld <= w_issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    assign w_tap_sample = r_rd_vld ? $signed(r_rd_data) : '0;

    // multiply stage, then accumulate
    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_prod <= PROD_W'(w_tap_sample * $signed({1'b0, r_coef}));
        end
        if (w_accept) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // clamp, scale and output register
    fls_sat #(
        .ACC_W (ACC_W),
        .SH    (SH)
    ) u_sat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_acc      (r_acc),
        .o_ready    (w_sat_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // a result is never loaded over one the receiver has not taken
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over a pending beat");

    // a new sample only enters with the mac pipeline empty
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> w_pipe_empty)
        else $error("sample accepted while taps in flight");

    // the last tap read ends the run
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FLS_RUN && r_tap == LAST_TAP) |=> (r_state == FLS_DRAIN))
        else $error("tap run did not end after the last tap");

    // a clamped result is always full scale
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata == 16'h7FFF || o_m_tdata == 16'h8001))
        else $error("clipped beat not at full scale");

endmodule

`default_nettype wire
